### design/ovle_pkg.sv
// ----------------------------------------------------------------------------
// ovle_pkg
// Shared types and codes of the ordered value list engine: operation and
// status codes, sequencer states and the item structs of both channels.
// ----------------------------------------------------------------------------
package ovle_pkg;

    // default number of list entries
    localparam int DEPTH_DEF = 16;

    // operation codes
    localparam logic [2:0] OP_INS_FRONT = 3'd0;
    localparam logic [2:0] OP_INS_BACK  = 3'd1;
    localparam logic [2:0] OP_FIND      = 3'd2;
    localparam logic [2:0] OP_REM_VALUE = 3'd3;
    localparam logic [2:0] OP_REM_FRONT = 3'd4;
    localparam logic [2:0] OP_CLEAR     = 3'd5;
    localparam logic [2:0] OP_QUERY     = 3'd6;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_SHIFT,
        S_FRONT_RD,
        S_BACK_RD,
        S_DONE
    } t_state;

    // input item
    typedef struct packed {
        logic        [2:0]  func;
        logic signed [31:0] data_value;
    } t_in_item;

    // result item
    typedef struct packed {
        logic        [1:0]  status;
        logic        [3:0]  found_position;
        logic signed [31:0] first_value;
        logic signed [31:0] last_value;
        logic        [4:0]  entry_count;
    } t_out_item;

endpackage

### design/ovle_ram.sv
// ----------------------------------------------------------------------------
// ovle_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module ovle_ram #(
    parameter int DW    = 32,
    parameter int DEPTH = ovle_pkg::DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DW-1:0]            i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DW-1:0]            o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/ovle_core.sv
// ----------------------------------------------------------------------------
// ovle_core
// Sequencer of the list engine. The list lives in a circular store (head
// pointer plus count); one read port and one compare unit are reused to walk
// entries for find and remove value, and to close the gap after the latter.
// ----------------------------------------------------------------------------
module ovle_core #(
    parameter int DEPTH = ovle_pkg::DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  ovle_pkg::t_in_item       i_item,
    output logic                     o_busy,
    output logic                     o_done,
    output ovle_pkg::t_out_item      o_res,
    // store port
    output logic                     o_we,
    output logic [$clog2(DEPTH)-1:0] o_waddr,
    output logic [31:0]              o_wdata,
    output logic [$clog2(DEPTH)-1:0] o_raddr,
    input  logic [31:0]              i_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(DEPTH);
    localparam logic [AW-1:0] ADR_TOP = AW'(DEPTH - 1);

    ovle_pkg::t_state r_state, n_state;
    logic [2:0]       r_op,       n_op;
    logic [31:0]      r_val,      n_val;
    logic [AW-1:0]    r_head,     n_head;
    logic [CW-1:0]    r_count,    n_count;
    logic [CW-1:0]    r_issue,    n_issue;
    logic             r_pend,     n_pend;
    logic [CW-1:0]    r_pend_idx, n_pend_idx;
    logic [CW-1:0]    r_pos,      n_pos;
    logic [1:0]       r_status,   n_status;
    logic [31:0]      r_first,    n_first;

    logic             hit;
    logic             empty;
    logic             full;

    // physical address of a list position
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] idx);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, idx[AW-1:0]};
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign hit   = r_pend && (i_rdata == r_val);
    assign empty = (r_count == '0);
    assign full  = (r_count == CNT_MAX);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ovle_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = ovle_pkg::S_EXEC;
                end
            end
            ovle_pkg::S_EXEC: begin
                case (r_op) inside
                    ovle_pkg::OP_FIND, ovle_pkg::OP_REM_VALUE: begin
                        n_state = ovle_pkg::S_SCAN;
                    end
                    default: begin
                        n_state = ovle_pkg::S_FRONT_RD;
                    end
                endcase
            end
            ovle_pkg::S_SCAN: begin
                if (hit) begin
                    n_state = (r_op == ovle_pkg::OP_REM_VALUE) ?
                              ovle_pkg::S_SHIFT : ovle_pkg::S_FRONT_RD;
                end else if (!r_pend && (r_issue >= r_count)) begin
                    n_state = ovle_pkg::S_FRONT_RD;
                end
            end
            ovle_pkg::S_SHIFT: begin
                if (!r_pend && (r_issue >= r_count)) begin
                    n_state = ovle_pkg::S_FRONT_RD;
                end
            end
            ovle_pkg::S_FRONT_RD: n_state = ovle_pkg::S_BACK_RD;
            ovle_pkg::S_BACK_RD:  n_state = ovle_pkg::S_DONE;
            ovle_pkg::S_DONE:     n_state = ovle_pkg::S_IDLE;
            default:              n_state = ovle_pkg::S_IDLE;
        endcase
    end

    // datapath and store control
    always_comb begin
        n_op       = r_op;
        n_val      = r_val;
        n_head     = r_head;
        n_count    = r_count;
        n_issue    = r_issue;
        n_pend     = r_pend;
        n_pend_idx = r_pend_idx;
        n_pos      = r_pos;
        n_status   = r_status;
        n_first    = r_first;
        o_we       = 1'b0;
        o_waddr    = phys(r_head, r_count);
        o_wdata    = r_val;
        o_raddr    = phys(r_head, r_issue);
        o_done     = 1'b0;
        unique case (r_state)
            ovle_pkg::S_IDLE: begin
                if (i_start) begin
                    n_op     = i_item.func;
                    n_val    = i_item.data_value;
                    n_status = ovle_pkg::ST_OK;
                    n_pos    = '0;
                    n_issue  = '0;
                    n_pend   = 1'b0;
                end
            end
            ovle_pkg::S_EXEC: begin
                case (r_op)
                    ovle_pkg::OP_INS_FRONT: begin
                        if (full) begin
                            n_status = ovle_pkg::ST_FULL;
                        end else begin
                            n_head  = (r_head == '0) ? ADR_TOP : r_head - AW'(1);
                            o_we    = 1'b1;
                            o_waddr = (r_head == '0) ? ADR_TOP : r_head - AW'(1);
                            n_count = r_count + CW'(1);
                        end
                    end
                    ovle_pkg::OP_INS_BACK: begin
                        if (full) begin
                            n_status = ovle_pkg::ST_FULL;
                        end else begin
                            o_we    = 1'b1;
                            n_count = r_count + CW'(1);
                        end
                    end
                    ovle_pkg::OP_REM_FRONT: begin
                        if (empty) begin
                            n_status = ovle_pkg::ST_EMPTY;
                        end else begin
                            n_head  = (r_head == ADR_TOP) ? '0 : r_head + AW'(1);
                            n_count = r_count - CW'(1);
                        end
                    end
                    ovle_pkg::OP_CLEAR: begin
                        n_count = '0;
                    end
                    default: begin
                    end
                endcase
            end
            // walk entries, one read issued and one compare per cycle
            ovle_pkg::S_SCAN: begin
                if (hit) begin
                    n_pos   = r_pend_idx;
                    n_issue = r_pend_idx + CW'(1);
                    n_pend  = 1'b0;
                end else if (r_issue < r_count) begin
                    n_issue    = r_issue + CW'(1);
                    n_pend     = 1'b1;
                    n_pend_idx = r_issue;
                end else if (r_pend) begin
                    n_pend = 1'b0;
                end else begin
                    n_status = ovle_pkg::ST_NOT_FOUND;
                end
            end
            // move each later entry down by one position
            ovle_pkg::S_SHIFT: begin
                if (r_pend) begin
                    o_we    = 1'b1;
                    o_waddr = phys(r_head, r_pend_idx - CW'(1));
                    o_wdata = i_rdata;
                end
                if (r_issue < r_count) begin
                    n_issue    = r_issue + CW'(1);
                    n_pend     = 1'b1;
                    n_pend_idx = r_issue;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_count = r_count - CW'(1);
                    end
                end
            end
            ovle_pkg::S_FRONT_RD: begin
                o_raddr = r_head;
            end
            ovle_pkg::S_BACK_RD: begin
                n_first = empty ? '0 : i_rdata;
                o_raddr = phys(r_head, r_count - CW'(1));
            end
            ovle_pkg::S_DONE: begin
                o_done = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // result fields
    always_comb begin
        o_res.status         = r_status;
        o_res.found_position = 4'(r_pos);
        o_res.first_value    = r_first;
        o_res.last_value     = empty ? '0 : i_rdata;
        o_res.entry_count    = 5'(r_count);
    end

    assign o_busy = (r_state != ovle_pkg::S_IDLE);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ovle_pkg::S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    // work registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_val      <= n_val;
        r_issue    <= n_issue;
        r_pend_idx <= n_pend_idx;
        r_pos      <= n_pos;
        r_status   <= n_status;
        r_first    <= n_first;
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("entry count beyond depth");

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= ADR_TOP)
        else $error("head pointer beyond depth");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ovle_pkg::S_DONE) |=> (r_state == ovle_pkg::S_IDLE))
        else $error("sequencer did not return to idle after result");

    a_ins_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ovle_pkg::S_EXEC && r_op == ovle_pkg::OP_INS_BACK && !full)
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert at back did not grow the list");
`endif

endmodule

### design/ordered_value_list_engine.sv
// ----------------------------------------------------------------------------
// ordered_value_list_engine
// Ordered list of up to DEPTH signed 32-bit values with insert, find,
// remove, clear and query operations; one result item per input item.
// ----------------------------------------------------------------------------
//  channel   ports                        handshake
//  --------  ---------------------------  ---------------------------------
//  input     i_start, i_item, o_busy      taken when i_start && !o_busy
//  result    o_strobe, o_result           valid for the single strobe cycle
//
//  An item is taken at the edge where i_start is high and o_busy low; o_busy
//  stays high until its result is out. For insert, remove front, clear and
//  query the sequencer steps through the execute, front read, back read and
//  done states, and the strobe is registered from the done state. Find adds
//  a walk through the store at one entry per cycle, which stops at the first
//  match; on a match, remove value then adds a pass that moves the later
//  entries down. The single read port of the value store sets the pace of
//  both walks. Reset (synchronous, active low) empties the list; the store
//  itself is not cleared. The result cannot be stalled.
// ----------------------------------------------------------------------------
module ordered_value_list_engine #(
    parameter int DEPTH = ovle_pkg::DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  ovle_pkg::t_in_item  i_item,
    output logic                o_busy,
    output logic                o_strobe,
    output ovle_pkg::t_out_item o_result
);

    localparam int AW = $clog2(DEPTH);

    logic                core_done;
    ovle_pkg::t_out_item core_res;
    logic                we;
    logic [AW-1:0]       waddr;
    logic [31:0]         wdata;
    logic [AW-1:0]       raddr;
    logic [31:0]         rdata;
    logic                r_strobe;
    ovle_pkg::t_out_item r_result;

    // sequencer and compare unit
    ovle_core #(
        .DEPTH (DEPTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_item  (i_item),
        .o_busy  (o_busy),
        .o_done  (core_done),
        .o_res   (core_res),
        .o_we    (we),
        .o_waddr (waddr),
        .o_wdata (wdata),
        .o_raddr (raddr),
        .i_rdata (rdata)
    );

    // value store
    ovle_ram #(
        .DW    (32),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= core_done;
        end
    end

    // result item register
    always_ff @(posedge i_clk) begin
        if (core_done) begin
            r_result <= core_res;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

`ifndef NO_ASSERTIONS
    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held longer than one cycle");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !o_busy)
        else $error("result shown while still busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted item did not raise busy");
`endif

endmodule
